// ===== rtl/core/sap_pkg.sv =====
// Shared types and constants for the synchrotron angular power unit.
`default_nettype none

package sap_pkg;

	typedef enum logic [2:0] {
		FOP_MUL,
		FOP_ADD,
		FOP_SUB,
		FOP_DIV,
		FOP_SQRT
	} fop_t;

	localparam int FPU_ITER = 26;
	localparam int FPU_LAT  = FPU_ITER + 6;
	localparam int OP_LEVELS = 19;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COSP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IG2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREF = 3'd4;

	localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
	localparam logic [31:0] F_ONE     = 32'h3F80_0000;
	localparam logic [31:0] F_3HALF   = 32'h3FC0_0000;
	localparam logic [31:0] F_HALF    = 32'h3F00_0000;
	localparam logic [31:0] F_5EIGHTH = 32'h3F20_0000;
	localparam logic [31:0] F_EIGHTH  = 32'h3E00_0000;

endpackage

`default_nettype wire

// ===== rtl/core/sap_channels.sv =====
// Stream channel interfaces for the angle samples and the power results.
`default_nettype none

interface sap_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] sin_view;
	logic [31:0] cos_view;
	modport source (output valid, output sin_view, output cos_view, input ready);
	modport sink (input valid, input sin_view, input cos_view, output ready);
endinterface

interface sap_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] angular_power;
	modport source (output valid, output angular_power, input ready);
	modport sink (input valid, input angular_power, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sap_fpu.sv =====
// Pipelined binary32 unit: multiply, add, subtract, divide and square root.
`default_nettype none

module sap_fpu import sap_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  fop_t        op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               inf;
		logic               nan;
		logic signed [10:0] ex;
		logic [23:0]        man;
	} unp_t;

	typedef struct packed {
		logic               spec;
		logic [31:0]        sbits;
		fop_t               op;
		logic               sign;
		logic signed [10:0] ex;
		logic [47:0]        prod;
		logic [26:0]        big;
		logic [26:0]        sml;
		logic               sub;
		logic [29:0]        rem;
		logic [51:0]        xs;
		logic [23:0]        dvs;
	} s3_t;

	typedef struct packed {
		logic               spec;
		logic [31:0]        sbits;
		logic               zero;
		logic               sign;
		logic signed [10:0] ex;
		logic [26:0]        sig;
		logic               iter;
		logic               sq;
		logic [29:0]        rem;
		logic [25:0]        root;
		logic [51:0]        xs;
		logic [23:0]        dvs;
	} it_t;

	typedef struct packed {
		logic        spec;
		logic [31:0] sbits;
		logic        zero;
		logic        ovf;
		logic        sign;
		logic [7:0]  bexp;
		logic [26:0] sig;
	} rnd_t;

	function automatic unp_t unpack(input logic [31:0] x);
		unp_t       u;
		logic [4:0] lz;
		lz = '0;
		for (int i = 0; i < 23; i++) begin
			if (x[i]) lz = 5'(22 - i);
		end
		u.sign = x[31];
		u.nan  = (&x[30:23]) & (|x[22:0]);
		u.inf  = (&x[30:23]) & ~(|x[22:0]);
		u.zero = ~(|x[30:0]);
		if (x[30:23] == 8'd0) begin
			u.man = {x[22:0], 1'b0} << lz;
			u.ex  = -11'sd127 - $signed({6'b0, lz});
		end else begin
			u.man = {1'b1, x[22:0]};
			u.ex  = $signed({3'b0, x[30:23]}) - 11'sd127;
		end
		return u;
	endfunction

	function automatic logic [26:0] shr_sticky(input logic [26:0] v, input logic [4:0] sh);
		logic [53:0] w;
		w = {v, 27'b0} >> sh;
		return {w[53:28], w[27] | (|w[26:0])};
	endfunction

	function automatic it_t step(input it_t t);
		it_t         o;
		logic [29:0] r;
		logic [29:0] tr;
		o  = t;
		r  = '0;
		tr = '0;
		if (t.iter) begin
			if (t.sq) begin
				r    = {t.rem[27:0], t.xs[51:50]};
				tr   = {2'b0, t.root, 2'b01};
				o.xs = {t.xs[49:0], 2'b0};
				if (r >= tr) begin
					o.rem  = r - tr;
					o.root = {t.root[24:0], 1'b1};
				end else begin
					o.rem  = r;
					o.root = {t.root[24:0], 1'b0};
				end
			end else begin
				if (t.rem >= {6'b0, t.dvs}) begin
					r      = t.rem - {6'b0, t.dvs};
					o.root = {t.root[24:0], 1'b1};
				end else begin
					r      = t.rem;
					o.root = {t.root[24:0], 1'b0};
				end
				o.rem = {r[28:0], 1'b0};
			end
		end
		return o;
	endfunction

	logic [31:0] a_s1, b_s1;
	fop_t        op_s1;
	logic [31:0] ra_s2, rb_s2;
	unp_t        ua_s2, ub_s2;
	fop_t        op_s2;
	s3_t         st_s3;
	s3_t         st_d;
	it_t         it_s4;
	it_t         it_d;
	it_t         it_s [FPU_ITER];
	rnd_t        rn_s31;
	rnd_t        rn_d;
	logic [31:0] b_eff;

	assign b_eff = (op_s1 == FOP_SUB) ? {~b_s1[31], b_s1[30:0]} : b_s1;

	always_comb begin
		unp_t               bg;
		unp_t               sm;
		logic signed [10:0] dif;
		logic signed [10:0] tmp;
		logic [4:0]         sh;
		logic               sx;
		logic               lt;
		logic               odd;
		logic [24:0]        mi;
		st_d    = '0;
		st_d.op = op_s2;
		sx      = ua_s2.sign ^ ub_s2.sign;
		bg      = ua_s2;
		sm      = ub_s2;
		dif     = '0;
		tmp     = '0;
		sh      = '0;
		lt      = 1'b0;
		odd     = 1'b0;
		mi      = '0;
		case (op_s2)
			FOP_MUL: begin
				st_d.sign = sx;
				st_d.ex   = ua_s2.ex + ub_s2.ex;
				st_d.prod = 48'(ua_s2.man) * 48'(ub_s2.man);
				if (ua_s2.nan || ub_s2.nan || (ua_s2.inf && ub_s2.zero) ||
				    (ua_s2.zero && ub_s2.inf)) begin
					st_d.spec  = 1'b1;
					st_d.sbits = F_QNAN;
				end else if (ua_s2.inf || ub_s2.inf) begin
					st_d.spec  = 1'b1;
					st_d.sbits = {sx, 8'hFF, 23'b0};
				end else if (ua_s2.zero || ub_s2.zero) begin
					st_d.spec  = 1'b1;
					st_d.sbits = {sx, 31'b0};
				end
			end
			FOP_ADD, FOP_SUB: begin
				if ((ub_s2.ex > ua_s2.ex) || (ub_s2.ex == ua_s2.ex && ub_s2.man > ua_s2.man)) begin
					bg = ub_s2;
					sm = ua_s2;
				end
				dif       = bg.ex - sm.ex;
				sh        = (dif > 11'sd27) ? 5'd27 : dif[4:0];
				st_d.big  = {bg.man, 3'b0};
				st_d.sml  = shr_sticky({sm.man, 3'b0}, sh);
				st_d.sub  = bg.sign ^ sm.sign;
				st_d.sign = bg.sign;
				st_d.ex   = bg.ex;
				if (ua_s2.nan || ub_s2.nan || (ua_s2.inf && ub_s2.inf && sx)) begin
					st_d.spec  = 1'b1;
					st_d.sbits = F_QNAN;
				end else if (ua_s2.inf) begin
					st_d.spec  = 1'b1;
					st_d.sbits = ra_s2;
				end else if (ub_s2.inf) begin
					st_d.spec  = 1'b1;
					st_d.sbits = rb_s2;
				end else if (ua_s2.zero && ub_s2.zero) begin
					st_d.spec  = 1'b1;
					st_d.sbits = {ua_s2.sign & ub_s2.sign, 31'b0};
				end else if (ua_s2.zero) begin
					st_d.spec  = 1'b1;
					st_d.sbits = rb_s2;
				end else if (ub_s2.zero) begin
					st_d.spec  = 1'b1;
					st_d.sbits = ra_s2;
				end
			end
			FOP_DIV: begin
				lt        = ua_s2.man < ub_s2.man;
				st_d.sign = sx;
				st_d.ex   = ua_s2.ex - ub_s2.ex - $signed({10'b0, lt});
				st_d.rem  = lt ? {5'b0, ua_s2.man, 1'b0} : {6'b0, ua_s2.man};
				st_d.dvs  = ub_s2.man;
				if (ua_s2.nan || ub_s2.nan || (ua_s2.zero && ub_s2.zero) ||
				    (ua_s2.inf && ub_s2.inf)) begin
					st_d.spec  = 1'b1;
					st_d.sbits = F_QNAN;
				end else if (ua_s2.inf || ub_s2.zero) begin
					st_d.spec  = 1'b1;
					st_d.sbits = {sx, 8'hFF, 23'b0};
				end else if (ua_s2.zero || ub_s2.inf) begin
					st_d.spec  = 1'b1;
					st_d.sbits = {sx, 31'b0};
				end
			end
			FOP_SQRT: begin
				odd       = ua_s2.ex[0];
				mi        = odd ? {ua_s2.man, 1'b0} : {1'b0, ua_s2.man};
				tmp       = ua_s2.ex - $signed({10'b0, odd});
				st_d.ex   = tmp >>> 1;
				st_d.xs   = {mi, 27'b0};
				if (ua_s2.nan || (ua_s2.sign && !ua_s2.zero)) begin
					st_d.spec  = 1'b1;
					st_d.sbits = F_QNAN;
				end else if (ua_s2.zero || ua_s2.inf) begin
					st_d.spec  = 1'b1;
					st_d.sbits = ra_s2;
				end
			end
			default: begin
				st_d.spec  = 1'b1;
				st_d.sbits = F_QNAN;
			end
		endcase
	end

	always_comb begin
		logic [27:0] sum;
		logic [4:0]  lz;
		it_d       = '0;
		it_d.spec  = st_s3.spec;
		it_d.sbits = st_s3.sbits;
		it_d.sign  = st_s3.sign;
		it_d.ex    = st_s3.ex;
		it_d.rem   = st_s3.rem;
		it_d.xs    = st_s3.xs;
		it_d.dvs   = st_s3.dvs;
		sum        = '0;
		lz         = '0;
		case (st_s3.op)
			FOP_MUL: begin
				if (st_s3.prod[47]) begin
					it_d.sig = {st_s3.prod[47:22], |st_s3.prod[21:0]};
					it_d.ex  = st_s3.ex + 11'sd1;
				end else begin
					it_d.sig = {st_s3.prod[46:21], |st_s3.prod[20:0]};
				end
			end
			FOP_ADD, FOP_SUB: begin
				sum = st_s3.sub ? ({1'b0, st_s3.big} - {1'b0, st_s3.sml})
				                : ({1'b0, st_s3.big} + {1'b0, st_s3.sml});
				for (int i = 0; i < 27; i++) begin
					if (sum[i]) lz = 5'(26 - i);
				end
				if (sum == 28'd0) begin
					it_d.zero = 1'b1;
				end else if (sum[27]) begin
					it_d.sig = {sum[27:2], sum[1] | sum[0]};
					it_d.ex  = st_s3.ex + 11'sd1;
				end else begin
					it_d.sig = sum[26:0] << lz;
					it_d.ex  = st_s3.ex - $signed({6'b0, lz});
				end
			end
			FOP_DIV: begin
				it_d.iter = 1'b1;
			end
			FOP_SQRT: begin
				it_d.iter = 1'b1;
				it_d.sq   = 1'b1;
			end
			default: begin
				it_d.spec  = 1'b1;
				it_d.sbits = F_QNAN;
			end
		endcase
	end

	always_comb begin
		it_t                t;
		logic [26:0]        sg;
		logic signed [10:0] d;
		logic [4:0]         sh;
		t          = it_s[FPU_ITER-1];
		sg         = t.iter ? {t.root, |t.rem} : t.sig;
		d          = -11'sd126 - t.ex;
		sh         = (d > 11'sd27) ? 5'd27 : d[4:0];
		rn_d.spec  = t.spec;
		rn_d.sbits = t.sbits;
		rn_d.zero  = t.zero;
		rn_d.sign  = t.sign;
		rn_d.ovf   = 1'b0;
		if (t.ex > 11'sd127) begin
			rn_d.ovf  = 1'b1;
			rn_d.bexp = 8'hFF;
			rn_d.sig  = sg;
		end else if (t.ex < -11'sd126) begin
			rn_d.bexp = 8'd0;
			rn_d.sig  = shr_sticky(sg, sh);
		end else begin
			rn_d.bexp = 8'(t.ex + 11'sd127);
			rn_d.sig  = sg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a;
			b_s1   <= b;
			op_s1  <= op;
			ra_s2  <= a_s1;
			rb_s2  <= b_eff;
			ua_s2  <= unpack(a_s1);
			ub_s2  <= unpack(b_eff);
			op_s2  <= op_s1;
			st_s3  <= st_d;
			it_s4  <= it_d;
			it_s[0] <= step(it_s4);
			for (int i = 1; i < FPU_ITER; i++) begin
				it_s[i] <= step(it_s[i-1]);
			end
			rn_s31 <= rn_d;
		end
	end

	always_ff @(posedge clk) begin
		logic        rup;
		logic [30:0] mag;
		rup = rn_s31.sig[2] & (rn_s31.sig[3] | rn_s31.sig[1] | rn_s31.sig[0]);
		mag = {rn_s31.bexp, rn_s31.sig[25:3]} + {30'b0, rup};
		if (en) begin
			if (rn_s31.spec) begin
				y <= rn_s31.sbits;
			end else if (rn_s31.zero) begin
				y <= 32'h0;
			end else if (rn_s31.ovf) begin
				y <= {rn_s31.sign, 8'hFF, 23'b0};
			end else begin
				y <= {rn_s31.sign, mag};
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/synchrotron_angular_power_unit.sv =====
// Pipeline: 19 dependent float operations of 32 stages each plus the output register;
// one item per cycle sustained while the result channel is not back-pressured.
// The length is set by the divide and square-root recurrence, one quotient or root
// bit per stage, which every operation slot shares so the slots line up.
// Reset clears all valid bits and sets the configuration registers to +0.0.
`default_nettype none

module synchrotron_angular_power_unit import sap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sap_in_if.sink               sample,
	sap_out_if.source            result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data
);

	localparam int L = FPU_LAT;
	localparam int VLEN = OP_LEVELS * L;

	logic [31:0] beta_q, cosp_q, sinp_q, ig2_q, pref_q;
	logic        en;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [31:0] sv_q  [5*L];
	logic [31:0] q1_q  [3*L];
	logic [31:0] f_q   [13*L];
	logic [31:0] eta_q [12*L];
	logic [31:0] qd_q  [10*L];
	logic [31:0] xi2_q [3*L];
	logic [31:0] c1_q  [L];
	logic [31:0] c2_q  [L];
	logic [31:0] p1_q  [2*L];
	logic        v_q   [VLEN];

	logic [31:0] t1, q0, tt, q1, kap, ik, ik2, e1, e2, f, qv, eta, ee, den, xi2, rt;
	logic [31:0] xi3, xi5, c1, xi7, a1, c2, p1, a2, p2, dd, d2, res;

	assign en            = !out_valid_q || result.ready;
	assign sample.ready  = en;
	assign result.valid  = out_valid_q;
	assign result.angular_power = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= '0;
			cosp_q <= '0;
			sinp_q <= '0;
			ig2_q  <= '0;
			pref_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BETA: beta_q <= wr_data;
				REG_COSP: cosp_q <= wr_data;
				REG_SINP: sinp_q <= wr_data;
				REG_IG2:  ig2_q  <= wr_data;
				REG_PREF: pref_q <= wr_data;
				default: ;
			endcase
		end
	end

	sap_fpu u_t1  (.clk, .en, .op(FOP_MUL),  .a(beta_q), .b(sample.cos_view), .y(t1));
	sap_fpu u_q0  (.clk, .en, .op(FOP_MUL),  .a(sample.sin_view), .b(sample.sin_view), .y(q0));
	sap_fpu u_t   (.clk, .en, .op(FOP_MUL),  .a(t1), .b(cosp_q), .y(tt));
	sap_fpu u_q1  (.clk, .en, .op(FOP_MUL),  .a(q0), .b(ig2_q), .y(q1));
	sap_fpu u_kap (.clk, .en, .op(FOP_SUB),  .a(F_ONE), .b(tt), .y(kap));
	sap_fpu u_ik  (.clk, .en, .op(FOP_DIV),  .a(F_ONE), .b(kap), .y(ik));
	sap_fpu u_ik2 (.clk, .en, .op(FOP_MUL),  .a(ik), .b(ik), .y(ik2));
	sap_fpu u_e1  (.clk, .en, .op(FOP_MUL),  .a(ik), .b(beta_q), .y(e1));
	sap_fpu u_e2  (.clk, .en, .op(FOP_MUL),  .a(e1), .b(sv_q[5*L-1]), .y(e2));
	sap_fpu u_f   (.clk, .en, .op(FOP_MUL),  .a(pref_q), .b(ik2), .y(f));
	sap_fpu u_q   (.clk, .en, .op(FOP_MUL),  .a(q1_q[3*L-1]), .b(ik2), .y(qv));
	sap_fpu u_eta (.clk, .en, .op(FOP_MUL),  .a(e2), .b(sinp_q), .y(eta));
	sap_fpu u_ee  (.clk, .en, .op(FOP_MUL),  .a(eta), .b(eta), .y(ee));
	sap_fpu u_den (.clk, .en, .op(FOP_SUB),  .a(F_ONE), .b(ee), .y(den));
	sap_fpu u_xi2 (.clk, .en, .op(FOP_DIV),  .a(F_ONE), .b(den), .y(xi2));
	sap_fpu u_rt  (.clk, .en, .op(FOP_SQRT), .a(xi2), .b(32'h0), .y(rt));
	sap_fpu u_xi3 (.clk, .en, .op(FOP_MUL),  .a(xi2_q[L-1]), .b(rt), .y(xi3));
	sap_fpu u_xi5 (.clk, .en, .op(FOP_MUL),  .a(xi3), .b(xi2_q[2*L-1]), .y(xi5));
	sap_fpu u_c1  (.clk, .en, .op(FOP_MUL),  .a(F_HALF), .b(xi3), .y(c1));
	sap_fpu u_xi7 (.clk, .en, .op(FOP_MUL),  .a(xi5), .b(xi2_q[3*L-1]), .y(xi7));
	sap_fpu u_a1  (.clk, .en, .op(FOP_MUL),  .a(F_3HALF), .b(xi5), .y(a1));
	sap_fpu u_c2  (.clk, .en, .op(FOP_MUL),  .a(F_EIGHTH), .b(xi5), .y(c2));
	sap_fpu u_p1  (.clk, .en, .op(FOP_SUB),  .a(a1), .b(c1_q[L-1]), .y(p1));
	sap_fpu u_a2  (.clk, .en, .op(FOP_MUL),  .a(F_5EIGHTH), .b(xi7), .y(a2));
	sap_fpu u_p2  (.clk, .en, .op(FOP_SUB),  .a(a2), .b(c2_q[L-1]), .y(p2));
	sap_fpu u_d   (.clk, .en, .op(FOP_MUL),  .a(qd_q[10*L-1]), .b(p2), .y(dd));
	sap_fpu u_d2  (.clk, .en, .op(FOP_SUB),  .a(p1_q[2*L-1]), .b(dd), .y(d2));
	sap_fpu u_res (.clk, .en, .op(FOP_MUL),  .a(f_q[12*L-1]), .b(d2), .y(res));

	// align operands that skip levels
	always_ff @(posedge clk) begin
		if (en) begin
			sv_q[0]  <= sample.sin_view;
			q1_q[0]  <= q1;
			f_q[0]   <= f;
			eta_q[0] <= eta;
			qd_q[0]  <= qv;
			xi2_q[0] <= xi2;
			c1_q[0]  <= c1;
			c2_q[0]  <= c2;
			p1_q[0]  <= p1;
			for (int i = 1; i < 5*L; i++) sv_q[i] <= sv_q[i-1];
			for (int i = 1; i < 3*L; i++) q1_q[i] <= q1_q[i-1];
			for (int i = 1; i < 13*L; i++) f_q[i] <= f_q[i-1];
			for (int i = 1; i < 12*L; i++) eta_q[i] <= eta_q[i-1];
			for (int i = 1; i < 10*L; i++) qd_q[i] <= qd_q[i-1];
			for (int i = 1; i < 3*L; i++) xi2_q[i] <= xi2_q[i-1];
			for (int i = 1; i < L; i++) c1_q[i] <= c1_q[i-1];
			for (int i = 1; i < L; i++) c2_q[i] <= c2_q[i-1];
			for (int i = 1; i < 2*L; i++) p1_q[i] <= p1_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLEN; i++) v_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= sample.valid;
			for (int i = 1; i < VLEN; i++) v_q[i] <= v_q[i-1];
			out_valid_q <= v_q[VLEN-1];
		end
	end

	// eta of zero takes the plain prefactor term
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= (eta_q[12*L-1][30:0] == 31'd0) ? f_q[13*L-1] : res;
		end
	end

endmodule

`default_nettype wire
